// File: sv/dirichlet_divisor_transform_macros.svh
// Assertion macros shared by the Dirichlet transform RTL.
`ifndef DIRICHLET_DIVISOR_TRANSFORM_MACROS_SVH
`define DIRICHLET_DIVISOR_TRANSFORM_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ddt_pkg.sv
// Shared types and constants for the Dirichlet divisor/multiple transform.
package ddt_pkg;

  // Field widths fixed by the stream format
  localparam int IDX_W       = 11;
  localparam int VAL_W       = 30;
  localparam int LEN_W       = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;

  // Default sizing
  localparam int DEF_MAX_LENGTH = 1024;
  localparam int DEF_MAX_PRIMES = 256;

  // Prime modulus
  localparam logic [VAL_W-1:0] MODULUS = 30'd998244353;

  // Operation codes carried in tuser
  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE   = 2'd2;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_PUSH,
    ST_SIEVE,
    ST_T_PRIME,
    ST_T_PLOAD,
    ST_T_TOP,
    ST_T_RD1,
    ST_T_RD2,
    ST_T_WR
  } ddt_state_t;

  // Sieve sequencer states
  typedef enum logic [2:0] {
    SV_IDLE,
    SV_CLEAR,
    SV_RD,
    SV_CHK,
    SV_PRD,
    SV_MUL,
    SV_MCHK
  } sv_state_t;

  // Sieve status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } sieve_stat_t;

endpackage

// File: sv/ddt_sieve.sv
// Linear prime sieve with smallest-factor table and prime list memory.
module ddt_sieve #(
  parameter int MAX_LENGTH = ddt_pkg::DEF_MAX_LENGTH,
  parameter int MAX_PRIMES = ddt_pkg::DEF_MAX_PRIMES
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [$clog2(MAX_LENGTH+1)-1:0]          n,
  output ddt_pkg::sieve_stat_t                     stat,
  output logic [$clog2(MAX_PRIMES+1)-1:0]          count,
  input  logic [((MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1)-1:0] prime_addr,
  output logic [$clog2(MAX_LENGTH+1)-1:0]          prime_data
);

  localparam int AW    = $clog2(MAX_LENGTH + 1);
  localparam int CW    = $clog2(MAX_PRIMES + 1);
  localparam int PW    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int DEPTH = MAX_LENGTH + 1;

  ddt_pkg::sv_state_t sstate, sstate_next;

  logic [AW-1:0]   sc;          // clear pointer
  logic [AW-1:0]   si;          // outer index
  logic [AW-1:0]   lp;          // smallest prime factor of si
  logic [AW-1:0]   pr;          // current prime
  logic [CW-1:0]   k;           // prime list cursor
  logic [2*AW-1:0] prod;        // si * pr
  logic            done;

  // Smallest-factor table, zero means not yet marked
  logic [AW-1:0] spf [DEPTH];
  logic [AW-1:0] spf_rd;
  logic          spf_we;
  logic [AW-1:0] spf_waddr;
  logic [AW-1:0] spf_wdata;

  // Prime list
  logic [AW-1:0] plist [MAX_PRIMES];
  logic [AW-1:0] plist_rd;
  logic          plist_we;
  logic [PW-1:0] plist_raddr;

  logic          busy;
  logic          i_last;
  logic          add_prime;
  logic          prod_over;

  assign busy      = (sstate != ddt_pkg::SV_IDLE);
  assign stat      = '{busy: busy, done: done};
  assign prime_data = plist_rd;
  assign i_last    = (si == n);
  assign add_prime = (spf_rd == '0) && (32'(count) < MAX_PRIMES);
  assign prod_over = (prod > (2*AW)'(n));

  // Next state
  always_comb begin
    sstate_next = sstate;
    unique case (sstate)
      ddt_pkg::SV_IDLE: begin
        if (start) sstate_next = ddt_pkg::SV_CLEAR;
      end
      ddt_pkg::SV_CLEAR: begin
        if (sc == n) sstate_next = (n < AW'(2)) ? ddt_pkg::SV_IDLE : ddt_pkg::SV_RD;
      end
      ddt_pkg::SV_RD:  sstate_next = ddt_pkg::SV_CHK;
      ddt_pkg::SV_CHK: sstate_next = ddt_pkg::SV_PRD;
      ddt_pkg::SV_PRD: begin
        if (k == count) sstate_next = i_last ? ddt_pkg::SV_IDLE : ddt_pkg::SV_RD;
        else sstate_next = ddt_pkg::SV_MUL;
      end
      ddt_pkg::SV_MUL: sstate_next = ddt_pkg::SV_MCHK;
      ddt_pkg::SV_MCHK: begin
        if (prod_over || (pr == lp)) begin
          sstate_next = i_last ? ddt_pkg::SV_IDLE : ddt_pkg::SV_RD;
        end else begin
          sstate_next = ddt_pkg::SV_PRD;
        end
      end
      default: sstate_next = ddt_pkg::SV_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    spf_we      = 1'b0;
    spf_waddr   = sc;
    spf_wdata   = '0;
    plist_we    = 1'b0;
    plist_raddr = busy ? k[PW-1:0] : prime_addr;
    unique case (sstate)
      ddt_pkg::SV_CLEAR: begin
        spf_we = 1'b1;
      end
      ddt_pkg::SV_CHK: begin
        plist_we = add_prime;
      end
      ddt_pkg::SV_MCHK: begin
        spf_we    = !prod_over;
        spf_waddr = prod[AW-1:0];
        spf_wdata = pr;
      end
      default: ;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (spf_we) spf[spf_waddr] <= spf_wdata;
    if (sstate == ddt_pkg::SV_RD) spf_rd <= spf[si];
    if (plist_we) plist[count[PW-1:0]] <= si;
    plist_rd <= plist[plist_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sstate <= ddt_pkg::SV_IDLE;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      sstate <= sstate_next;
      done   <= busy && (sstate_next == ddt_pkg::SV_IDLE);
      if (sstate == ddt_pkg::SV_IDLE && start) count <= '0;
      if (plist_we) count <= count + CW'(1);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (sstate)
      ddt_pkg::SV_IDLE: begin
        sc <= '0;
        si <= AW'(2);
      end
      ddt_pkg::SV_CLEAR: sc <= sc + AW'(1);
      ddt_pkg::SV_CHK: begin
        lp <= (spf_rd == '0) ? si : spf_rd;
        k  <= '0;
      end
      ddt_pkg::SV_PRD: begin
        if (k == count && !i_last) si <= si + AW'(1);
      end
      ddt_pkg::SV_MUL: begin
        pr   <= plist_rd;
        prod <= (2*AW)'(si) * (2*AW)'(plist_rd);
      end
      ddt_pkg::SV_MCHK: begin
        if (prod_over || (pr == lp)) begin
          if (!i_last) si <= si + AW'(1);
        end else begin
          k <= k + CW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/dirichlet_divisor_transform.sv
// Top level: element store, transform sequencer and shared modular unit.
//
//  Channel | Signals                          | Direction | Content
//  cfg     | cfg_valid/ready, index, data     | in        | register writes
//  s_      | s_tvalid/tready, tdata, tuser    | in        | load or read requests
//  m_      | m_tvalid/tready, tdata           | out       | read results
//
// A load is written from the idle state; a read registers the memory word, then waits
// in a push state until m_tdata is free. A load at index n, the configured length,
// starts a burst: the sieve clears n+1 factor table entries and visits each index with
// read, check and marking steps; then per prime the sequencer finds the top multiple
// for descending passes and updates each element with two reads and one write.
// rst is synchronous and clears control state; s_tready is low during bursts.
`include "dirichlet_divisor_transform_macros.svh"

module dirichlet_divisor_transform #(
  parameter int MAX_LENGTH = ddt_pkg::DEF_MAX_LENGTH,
  parameter int MAX_PRIMES = ddt_pkg::DEF_MAX_PRIMES
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ddt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddt_pkg::LEN_W-1:0]          cfg_data,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ddt_pkg::IN_TDATA_W-1:0]     s_tdata,   // index[10:0], value[40:11]
  input  logic [0:0]                         s_tuser,   // operation[0]
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ddt_pkg::OUT_TDATA_W-1:0]    m_tdata    // result[29:0]
);

  localparam int AW    = $clog2(MAX_LENGTH + 1);
  localparam int CW    = $clog2(MAX_PRIMES + 1);
  localparam int PW    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int DEPTH = MAX_LENGTH + 1;
  localparam int IW    = ddt_pkg::IDX_W;
  localparam int VW    = ddt_pkg::VAL_W;

  ddt_pkg::ddt_state_t state, state_next;

  // Configuration registers
  logic [ddt_pkg::LEN_W-1:0] length;
  logic                      direction;
  logic                      inverse;

  // Transform registers
  logic [CW-1:0]  tk;
  logic [AW-1:0]  tp;
  logic [AW-1:0]  ti;
  logic [AW:0]    tm;
  logic [VW-1:0]  src_val;
  logic           rd_ok;
  logic [VW-1:0]  out_val;

  // Element store
  logic [VW-1:0]  emem [DEPTH];
  logic [VW-1:0]  mrdata;
  logic           mre;
  logic [AW-1:0]  mraddr;
  logic           mwe;
  logic [AW-1:0]  mwaddr;
  logic [VW-1:0]  mwdata;

  // Sieve link
  ddt_pkg::sieve_stat_t sv_stat;
  logic [CW-1:0]  sv_count;
  logic [AW-1:0]  prime_data;
  logic           sv_start;

  // Decoded request
  logic [IW-1:0]  in_idx;
  logic [VW-1:0]  in_val;
  logic [VW-1:0]  load_val;
  logic [AW-1:0]  in_addr;
  logic           idx_ok;
  logic           idx_last;
  logic [AW-1:0]  n_eff;

  // Loop control
  logic           bwd;
  logic [AW:0]    sum_mp;
  logic           sum_over;
  logic [AW-1:0]  src_addr;
  logic [AW-1:0]  dst_addr;
  logic           out_free;

  // Shared modular unit
  logic [VW:0]    mod_raw;
  logic [VW-1:0]  mod_res;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {(ddt_pkg::OUT_TDATA_W - VW)'(0), out_val};
  assign out_free  = !m_tvalid || m_tready;

  // Request decode
  assign in_idx   = s_tdata[IW-1:0];
  assign in_val   = s_tdata[IW+VW-1:IW];
  assign load_val = (in_val >= ddt_pkg::MODULUS) ? (in_val - ddt_pkg::MODULUS) : in_val;
  assign in_addr  = AW'(in_idx);
  assign idx_ok   = (in_idx != '0) && (32'(in_idx) <= MAX_LENGTH);
  assign idx_last = idx_ok && (32'(in_idx) == 32'(n_eff));

  always_comb begin
    if (32'(length) > MAX_LENGTH) n_eff = AW'(MAX_LENGTH);
    else n_eff = AW'(length);
  end

  // Pass order and operand roles
  assign bwd      = direction ^ inverse;
  assign sum_mp   = tm + {1'b0, tp};
  assign sum_over = (sum_mp > {1'b0, n_eff});
  assign src_addr = direction ? tm[AW-1:0] : ti;
  assign dst_addr = direction ? ti : tm[AW-1:0];

  // Modular add or subtract: stored value op source value
  always_comb begin
    if (!inverse) begin
      mod_raw = {1'b0, mrdata} + {1'b0, src_val};
      mod_res = (mod_raw >= {1'b0, ddt_pkg::MODULUS}) ?
                VW'(mod_raw - {1'b0, ddt_pkg::MODULUS}) : VW'(mod_raw);
    end else begin
      mod_raw = {1'b0, mrdata} - {1'b0, src_val};
      mod_res = (mrdata < src_val) ?
                VW'(mod_raw + {1'b0, ddt_pkg::MODULUS}) : VW'(mod_raw);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ddt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == ddt_pkg::OP_READ) state_next = ddt_pkg::ST_RD_PUSH;
          else if (idx_last) state_next = ddt_pkg::ST_SIEVE;
        end
      end
      ddt_pkg::ST_RD_PUSH: begin
        if (out_free) state_next = ddt_pkg::ST_IDLE;
      end
      ddt_pkg::ST_SIEVE: begin
        if (sv_stat.done) state_next = ddt_pkg::ST_T_PRIME;
      end
      ddt_pkg::ST_T_PRIME: begin
        state_next = (tk == sv_count) ? ddt_pkg::ST_IDLE : ddt_pkg::ST_T_PLOAD;
      end
      ddt_pkg::ST_T_PLOAD: state_next = bwd ? ddt_pkg::ST_T_TOP : ddt_pkg::ST_T_RD1;
      ddt_pkg::ST_T_TOP: begin
        if (sum_over) state_next = ddt_pkg::ST_T_RD1;
      end
      ddt_pkg::ST_T_RD1: state_next = ddt_pkg::ST_T_RD2;
      ddt_pkg::ST_T_RD2: state_next = ddt_pkg::ST_T_WR;
      ddt_pkg::ST_T_WR: begin
        if (bwd) state_next = (ti == AW'(1)) ? ddt_pkg::ST_T_PRIME : ddt_pkg::ST_T_RD1;
        else state_next = sum_over ? ddt_pkg::ST_T_PRIME : ddt_pkg::ST_T_RD1;
      end
      default: state_next = ddt_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory controls
  always_comb begin
    s_tready = 1'b0;
    mre      = 1'b0;
    mraddr   = src_addr;
    mwe      = 1'b0;
    mwaddr   = dst_addr;
    mwdata   = mod_res;
    sv_start = 1'b0;
    unique case (state)
      ddt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == ddt_pkg::OP_READ) begin
            mre    = 1'b1;
            mraddr = in_addr;
          end else begin
            mwe      = idx_ok;
            mwaddr   = in_addr;
            mwdata   = load_val;
            sv_start = idx_last;
          end
        end
      end
      ddt_pkg::ST_T_RD1: mre = 1'b1;
      ddt_pkg::ST_T_RD2: begin
        mre    = 1'b1;
        mraddr = dst_addr;
      end
      ddt_pkg::ST_T_WR: mwe = 1'b1;
      default: ;
    endcase
  end

  // Element memory
  always_ff @(posedge clk) begin
    if (mwe) emem[mwaddr] <= mwdata;
    if (mre) mrdata <= emem[mraddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddt_pkg::ST_IDLE;
      m_tvalid  <= 1'b0;
      length    <= ddt_pkg::LEN_W'(ddt_pkg::DEF_MAX_LENGTH);
      direction <= 1'b0;
      inverse   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ddt_pkg::ST_RD_PUSH && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          ddt_pkg::CFG_LENGTH:    length    <= cfg_data;
          ddt_pkg::CFG_DIRECTION: direction <= cfg_data[0];
          ddt_pkg::CFG_INVERSE:   inverse   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Transform and result datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ddt_pkg::ST_IDLE: begin
        rd_ok <= idx_ok;
        tk    <= '0;
      end
      ddt_pkg::ST_RD_PUSH: begin
        if (out_free) out_val <= rd_ok ? mrdata : '0;
      end
      ddt_pkg::ST_T_PLOAD: begin
        tp <= prime_data;
        ti <= AW'(1);
        tm <= {1'b0, prime_data};
      end
      ddt_pkg::ST_T_TOP: begin
        if (!sum_over) begin
          tm <= sum_mp;
          ti <= ti + AW'(1);
        end
      end
      ddt_pkg::ST_T_RD2: src_val <= mrdata;
      ddt_pkg::ST_T_WR: begin
        if (bwd) begin
          if (ti == AW'(1)) tk <= tk + CW'(1);
          else begin
            tm <= tm - {1'b0, tp};
            ti <= ti - AW'(1);
          end
        end else begin
          if (sum_over) tk <= tk + CW'(1);
          else begin
            tm <= sum_mp;
            ti <= ti + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Prime sieve
  ddt_sieve #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_sieve (
    .clk        (clk),
    .rst        (rst),
    .start      (sv_start),
    .n          (n_eff),
    .stat       (sv_stat),
    .count      (sv_count),
    .prime_addr (tk[PW-1:0]),
    .prime_data (prime_data)
  );

  // Checks
  `DDT_ASSERT_IMP(a_busy_not_ready, sv_stat.busy, !s_tready, "request taken during sieve")
  `DDT_ASSERT_NXT(a_read_holds, s_tvalid && s_tready && (s_tuser == ddt_pkg::OP_READ), !s_tready, "ready right after read")
  `DDT_ASSERT_IMP(a_result_src, $rose(m_tvalid), $past(state) == ddt_pkg::ST_RD_PUSH, "result without read")

endmodule
